### rtl/toe_pkg.sv
// Shared types and codes for the topological order engine.
package toe_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CYCLE = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_SCAN,
        S_EDGE_WR,
        S_EDGE_DEG,
        S_EDGE_DEG2,
        S_EDGE_OUT,
        S_CLR,
        S_CNT_U,
        S_CNT_U2,
        S_CNT_K,
        S_CNT_K2,
        S_CNT_K3,
        S_SEED,
        S_SEED2,
        S_POP,
        S_POP2,
        S_POP3,
        S_VIS,
        S_VIS2,
        S_VIS3,
        S_EMIT,
        S_EMIT2,
        S_EMIT3
    } state_t;

endpackage

### rtl/topological_order_engine_unit.sv
// Top level of the topological order engine: edge updates and Kahn sort.
//
//  channel | ports                                  | direction
//  s_      | s_opcode, s_source_node, s_dest_node   | in
//  m_      | m_node_index, m_status, m_last         | out
//  cfg_    | cfg_data (node_count)                  | in
//
// One item at a time through one sequencer over synchronous RAMs.
// Add/remove read the source's list length, scan its successor slots (one slot per cycle),
// write the list and count, update the destination's degree and return a status;
// a bad index goes straight to the status result; opcode 3 returns with no result.
// A run clears working degrees, counts in-degrees, seeds and drains the queue, then emits.
// Reset is synchronous; a pass after reset clears counts and degrees with s_ready low;
// the other memory contents need none.
// Results wait in the output register; the sequencer stalls while it is full.
module topological_order_engine_unit #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_FANOUT = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [5:0] s_source_node,
    input  logic [5:0] s_dest_node,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_node_index,
    output logic [1:0] m_status,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);
    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FW = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
    localparam int CW = $clog2(MAX_FANOUT + 1);
    localparam int DW = $clog2(MAX_NODES + 1);
    localparam int TW = NW + FW;
    localparam int QW = $clog2(MAX_NODES + 1);

    toe_pkg::state_t state_reg, state_next;

    // memories
    logic [5:0]    succ_mem [MAX_NODES*MAX_FANOUT];
    logic [CW-1:0] cnt_mem  [MAX_NODES];
    logic [DW-1:0] deg_mem  [MAX_NODES];
    logic [DW-1:0] wdeg_mem [MAX_NODES];
    logic [NW-1:0] q_mem    [MAX_NODES];
    logic [NW-1:0] ord_mem  [MAX_NODES];

    logic [6:0]    ncfg_reg;
    logic [1:0]    op_reg;
    logic [5:0]    src_reg, dst_reg;
    logic [NW-1:0] u_reg;
    logic [CW-1:0] k_reg, c_reg, w_reg;
    logic          found_reg;
    logic [QW-1:0] head_reg, tail_reg, done_reg, n_reg;
    logic [NW-1:0] cur_reg;
    logic          clr_reg;
    logic [NW:0]   clr_idx_reg;
    toe_pkg::status_t op_st_reg;
    logic          dv_reg;
    logic [NW-1:0] dn_reg;

    // read ports (registered)
    logic [TW-1:0] succ_ra;
    logic [5:0]    succ_rd;
    logic          succ_we;
    logic [TW-1:0] succ_wa;
    logic [5:0]    succ_wd;
    logic [NW-1:0] cnt_ra;
    logic [CW-1:0] cnt_rd;
    logic          cnt_we;
    logic [NW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic [NW-1:0] deg_a;
    logic [DW-1:0] deg_rd;
    logic          deg_we;
    logic [DW-1:0] deg_wd;
    logic [NW-1:0] wdeg_ra, wdeg_wa;
    logic [DW-1:0] wdeg_rd, wdeg_wd;
    logic          wdeg_we;
    logic [NW-1:0] q_ra, q_wa, q_wd, q_rd;
    logic          q_we;
    logic [NW-1:0] ord_ra, ord_wa, ord_wd, ord_rd;
    logic          ord_we;

    always_ff @(posedge aclk) begin
        if (succ_we) succ_mem[succ_wa] <= succ_wd;
        succ_rd <= succ_mem[succ_ra];
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
        if (deg_we) deg_mem[deg_a] <= deg_wd;
        deg_rd <= deg_mem[deg_a];
        if (wdeg_we) wdeg_mem[wdeg_wa] <= wdeg_wd;
        wdeg_rd <= wdeg_mem[wdeg_ra];
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[q_ra];
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_rd <= ord_mem[ord_ra];
    end

    // output register
    logic          out_load;
    logic [5:0]    out_idx;
    logic [1:0]    out_st;
    logic          out_last;
    logic          m_valid_reg;
    logic [5:0]    m_idx_reg;
    logic [1:0]    m_st_reg;
    logic          m_last_reg;

    assign m_valid      = m_valid_reg;
    assign m_node_index = m_idx_reg;
    assign m_status     = m_st_reg;
    assign m_last       = m_last_reg;
    wire out_free = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == toe_pkg::S_IDLE) && !clr_reg;
    assign cfg_ready = 1'b1;

    logic [QW-1:0] n_eff;
    always_comb begin
        if (ncfg_reg == 7'd0) n_eff = QW'(1);
        else if (32'(ncfg_reg) > MAX_NODES) n_eff = QW'(MAX_NODES);
        else n_eff = QW'(ncfg_reg);
    end

    logic bad_in;
    assign bad_in = (QW'(s_source_node) >= n_eff) || (QW'(s_dest_node) >= n_eff)
                    || (32'(s_source_node) >= MAX_NODES) || (32'(s_dest_node) >= MAX_NODES);

    logic [CW-1:0] c_clip;
    assign c_clip = (32'(cnt_rd) > MAX_FANOUT) ? CW'(MAX_FANOUT) : cnt_rd;

    wire [NW-1:0] s_src_n = NW'(s_source_node);
    wire [NW-1:0] src_n   = NW'(src_reg);
    wire [NW-1:0] dst_n   = NW'(dst_reg);
    wire [NW-1:0] d_n     = NW'(succ_rd);
    wire d_in = (QW'(succ_rd) < n_reg) && (32'(succ_rd) < MAX_NODES);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            toe_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    priority if (toe_pkg::opcode_t'(s_opcode) == toe_pkg::OP_RUN)
                        state_next = toe_pkg::S_CLR;
                    else if (toe_pkg::opcode_t'(s_opcode) == toe_pkg::OP_NONE)
                        state_next = toe_pkg::S_IDLE;
                    else if (bad_in) state_next = toe_pkg::S_EDGE_OUT;
                    else state_next = toe_pkg::S_EDGE_RD;
                end
            end
            toe_pkg::S_EDGE_RD:   state_next = toe_pkg::S_EDGE_SCAN;
            toe_pkg::S_EDGE_SCAN: begin
                if (k_reg >= c_reg) begin
                    state_next = toe_pkg::S_EDGE_WR;
                end else begin
                    state_next = toe_pkg::S_EDGE_SCAN;
                end
            end
            toe_pkg::S_EDGE_WR:   state_next = toe_pkg::S_EDGE_DEG;
            toe_pkg::S_EDGE_DEG:  state_next = toe_pkg::S_EDGE_DEG2;
            toe_pkg::S_EDGE_DEG2: state_next = toe_pkg::S_EDGE_OUT;
            toe_pkg::S_EDGE_OUT:  if (out_free) state_next = toe_pkg::S_IDLE;
            toe_pkg::S_CLR: begin
                if (QW'(u_reg) + QW'(1) >= n_reg) state_next = toe_pkg::S_CNT_U;
            end
            toe_pkg::S_CNT_U:  state_next = toe_pkg::S_CNT_U2;
            toe_pkg::S_CNT_U2: state_next = toe_pkg::S_CNT_K;
            toe_pkg::S_CNT_K: begin
                if (k_reg >= c_reg) begin
                    if (QW'(u_reg) + QW'(1) >= n_reg) state_next = toe_pkg::S_SEED;
                    else state_next = toe_pkg::S_CNT_U;
                end else state_next = toe_pkg::S_CNT_K2;
            end
            toe_pkg::S_CNT_K2: state_next = toe_pkg::S_CNT_K3;
            toe_pkg::S_CNT_K3: state_next = toe_pkg::S_CNT_K;
            toe_pkg::S_SEED:   state_next = toe_pkg::S_SEED2;
            toe_pkg::S_SEED2: begin
                if (QW'(u_reg) + QW'(1) >= n_reg) state_next = toe_pkg::S_POP;
                else state_next = toe_pkg::S_SEED;
            end
            toe_pkg::S_POP: begin
                if (head_reg < tail_reg && done_reg < n_reg) state_next = toe_pkg::S_POP2;
                else state_next = toe_pkg::S_EMIT;
            end
            toe_pkg::S_POP2: state_next = toe_pkg::S_POP3;
            toe_pkg::S_POP3: state_next = toe_pkg::S_VIS;
            toe_pkg::S_VIS: begin
                if (k_reg >= c_reg) state_next = toe_pkg::S_POP;
                else state_next = toe_pkg::S_VIS2;
            end
            toe_pkg::S_VIS2: state_next = toe_pkg::S_VIS3;
            toe_pkg::S_VIS3: state_next = toe_pkg::S_VIS;
            toe_pkg::S_EMIT: begin
                if (done_reg != n_reg) begin
                    if (out_free) state_next = toe_pkg::S_IDLE;
                end else state_next = toe_pkg::S_EMIT2;
            end
            toe_pkg::S_EMIT2: state_next = toe_pkg::S_EMIT3;
            toe_pkg::S_EMIT3: begin
                if (out_free) begin
                    if (QW'(u_reg) + QW'(1) >= n_reg) state_next = toe_pkg::S_IDLE;
                    else state_next = toe_pkg::S_EMIT2;
                end
            end
            default: state_next = toe_pkg::S_IDLE;
        endcase
    end

    // memory controls and result
    always_comb begin
        succ_ra = '0; succ_we = 1'b0; succ_wa = '0; succ_wd = '0;
        cnt_ra = '0; cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
        deg_a = '0; deg_we = 1'b0; deg_wd = '0;
        wdeg_ra = '0; wdeg_wa = '0; wdeg_we = 1'b0; wdeg_wd = '0;
        q_ra = '0; q_wa = '0; q_we = 1'b0; q_wd = '0;
        ord_ra = '0; ord_wa = '0; ord_we = 1'b0; ord_wd = '0;
        out_load = 1'b0; out_idx = '0; out_st = toe_pkg::ST_OK; out_last = 1'b1;
        unique case (state_reg)
            toe_pkg::S_IDLE: begin
                cnt_ra = s_src_n;
                if (clr_reg) begin
                    cnt_we = 1'b1; cnt_wa = NW'(clr_idx_reg);
                    deg_we = 1'b1; deg_a = NW'(clr_idx_reg);
                end
            end
            toe_pkg::S_EDGE_RD: begin
                succ_ra = TW'(src_n) * TW'(MAX_FANOUT);
            end
            toe_pkg::S_EDGE_SCAN: begin
                succ_ra = TW'(src_n) * TW'(MAX_FANOUT) + TW'(k_reg) + TW'(1);
                if (k_reg < c_reg && op_reg == toe_pkg::OP_REMOVE && succ_rd != dst_reg) begin
                    succ_we = 1'b1;
                    succ_wa = TW'(src_n) * TW'(MAX_FANOUT) + TW'(w_reg);
                    succ_wd = succ_rd;
                end
            end
            toe_pkg::S_EDGE_WR: begin
                if (op_reg == toe_pkg::OP_ADD && !found_reg && 32'(c_reg) < MAX_FANOUT) begin
                    succ_we = 1'b1;
                    succ_wa = TW'(src_n) * TW'(MAX_FANOUT) + TW'(c_reg);
                    succ_wd = dst_reg;
                    cnt_we = 1'b1; cnt_wa = src_n; cnt_wd = c_reg + CW'(1);
                end
                if (op_reg == toe_pkg::OP_REMOVE) begin
                    cnt_we = 1'b1; cnt_wa = src_n; cnt_wd = w_reg;
                end
                deg_a = dst_n;
            end
            toe_pkg::S_EDGE_DEG: deg_a = dst_n;
            toe_pkg::S_EDGE_DEG2: begin
                deg_a = dst_n;
                if (op_reg == toe_pkg::OP_ADD && !found_reg && 32'(c_reg) < MAX_FANOUT) begin
                    deg_we = 1'b1; deg_wd = deg_rd + DW'(1);
                end
                if (op_reg == toe_pkg::OP_REMOVE && found_reg && deg_rd != '0) begin
                    deg_we = 1'b1; deg_wd = deg_rd - DW'(1);
                end
            end
            toe_pkg::S_EDGE_OUT: begin
                out_load = out_free;
                out_st = op_st_reg;
            end
            toe_pkg::S_CLR: begin
                wdeg_we = 1'b1; wdeg_wa = u_reg; wdeg_wd = '0;
            end
            toe_pkg::S_CNT_U: cnt_ra = u_reg;
            toe_pkg::S_CNT_U2: begin
                cnt_ra = u_reg;
                succ_ra = TW'(u_reg) * TW'(MAX_FANOUT);
            end
            toe_pkg::S_CNT_K: begin
                succ_ra = TW'(u_reg) * TW'(MAX_FANOUT) + TW'(k_reg);
            end
            toe_pkg::S_CNT_K2: wdeg_ra = d_n;
            toe_pkg::S_CNT_K3: begin
                if (dv_reg) begin
                    wdeg_we = 1'b1; wdeg_wa = dn_reg; wdeg_wd = wdeg_rd + DW'(1);
                end
            end
            toe_pkg::S_SEED: wdeg_ra = u_reg;
            toe_pkg::S_SEED2: begin
                if (wdeg_rd == '0 && tail_reg < n_reg) begin
                    q_we = 1'b1; q_wa = NW'(tail_reg); q_wd = u_reg;
                end
            end
            toe_pkg::S_POP: q_ra = NW'(head_reg);
            toe_pkg::S_POP2: begin
                cnt_ra = q_rd;
                ord_we = 1'b1; ord_wa = NW'(done_reg); ord_wd = q_rd;
            end
            toe_pkg::S_POP3: cnt_ra = cur_reg;
            toe_pkg::S_VIS: succ_ra = TW'(cur_reg) * TW'(MAX_FANOUT) + TW'(k_reg);
            toe_pkg::S_VIS2: wdeg_ra = d_n;
            toe_pkg::S_VIS3: begin
                if (dv_reg && wdeg_rd != '0) begin
                    wdeg_we = 1'b1; wdeg_wa = dn_reg; wdeg_wd = wdeg_rd - DW'(1);
                    if (wdeg_rd == DW'(1) && tail_reg < n_reg) begin
                        q_we = 1'b1; q_wa = NW'(tail_reg); q_wd = dn_reg;
                    end
                end
            end
            toe_pkg::S_EMIT: begin
                if (done_reg != n_reg) begin
                    out_load = out_free; out_st = toe_pkg::ST_CYCLE; out_last = 1'b1;
                end
            end
            toe_pkg::S_EMIT2: ord_ra = u_reg;
            toe_pkg::S_EMIT3: begin
                ord_ra = u_reg;
                out_load = out_free;
                out_idx = 6'(ord_rd);
                out_last = (QW'(u_reg) + QW'(1) >= n_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= toe_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            ncfg_reg    <= 7'd1;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) ncfg_reg <= cfg_data;
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + (NW+1)'(1);
                if (32'(clr_idx_reg) == MAX_NODES - 1) clr_reg <= 1'b0;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg  <= out_idx;
            m_st_reg   <= out_st;
            m_last_reg <= out_last;
        end
        unique case (state_reg)
            toe_pkg::S_IDLE: begin
                op_reg <= s_opcode; src_reg <= s_source_node; dst_reg <= s_dest_node;
                k_reg <= '0; w_reg <= '0; found_reg <= 1'b0; u_reg <= '0;
                n_reg <= n_eff; head_reg <= '0; tail_reg <= '0; done_reg <= '0;
                op_st_reg <= bad_in ? toe_pkg::ST_BAD : toe_pkg::ST_OK;
            end
            toe_pkg::S_EDGE_RD: c_reg <= c_clip;
            toe_pkg::S_EDGE_SCAN: begin
                if (k_reg < c_reg) begin
                    k_reg <= k_reg + CW'(1);
                    if (succ_rd == dst_reg) found_reg <= 1'b1;
                    else w_reg <= w_reg + CW'(1);
                end
            end
            toe_pkg::S_EDGE_WR: begin
                if (op_reg == toe_pkg::OP_ADD && !found_reg && 32'(c_reg) >= MAX_FANOUT)
                    op_st_reg <= toe_pkg::ST_FULL;
            end
            toe_pkg::S_CLR: if (QW'(u_reg) + QW'(1) < n_reg) u_reg <= u_reg + NW'(1);
                            else u_reg <= '0;
            toe_pkg::S_CNT_U: k_reg <= '0;
            toe_pkg::S_CNT_U2: c_reg <= c_clip;
            toe_pkg::S_CNT_K: begin
                if (k_reg >= c_reg) begin
                    if (QW'(u_reg) + QW'(1) < n_reg) u_reg <= u_reg + NW'(1);
                    else u_reg <= '0;
                end
            end
            toe_pkg::S_CNT_K2: begin
                dv_reg <= d_in; dn_reg <= d_n; k_reg <= k_reg + CW'(1);
            end
            toe_pkg::S_SEED2: begin
                if (wdeg_rd == '0 && tail_reg < n_reg) tail_reg <= tail_reg + QW'(1);
                if (QW'(u_reg) + QW'(1) < n_reg) u_reg <= u_reg + NW'(1);
                else u_reg <= '0;
            end
            toe_pkg::S_POP2: begin
                cur_reg <= q_rd; head_reg <= head_reg + QW'(1);
                done_reg <= done_reg + QW'(1); k_reg <= '0;
            end
            toe_pkg::S_POP3: c_reg <= c_clip;
            toe_pkg::S_VIS2: begin
                dv_reg <= d_in; dn_reg <= d_n; k_reg <= k_reg + CW'(1);
            end
            toe_pkg::S_VIS3: begin
                if (dv_reg && wdeg_rd == DW'(1) && tail_reg < n_reg)
                    tail_reg <= tail_reg + QW'(1);
            end
            toe_pkg::S_EMIT3: if (out_free) u_reg <= u_reg + NW'(1);
            default: ;
        endcase
    end

endmodule

### rtl/toe_checker.sv
// Port-level checks for the topological order engine, bound to the top level.
module toe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_opcode,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_node_index,
    input logic [1:0] m_status,
    input logic       m_last
);
    // status-only results carry node zero and close the request
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != toe_pkg::ST_OK |-> m_last && m_node_index == 6'd0)
        else $error("status result not last or nonzero node");

    // a request that starts work closes the input on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode != toe_pkg::OP_NONE |=> !s_ready)
        else $error("input still open after a working request");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_node_index) && $stable(m_status)
                               && $stable(m_last))
        else $error("result changed while stalled");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(m_valid) && !$isunknown(s_ready))
        else $error("handshake output unknown");
endmodule

bind topological_order_engine_unit toe_checker u_toe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_opcode(s_opcode), .m_valid(m_valid), .m_ready(m_ready),
    .m_node_index(m_node_index), .m_status(m_status), .m_last(m_last)
);
